### design/hsv_color_range_mask_defines.svh
// Assertion macros for the design module.
`ifndef HSV_COLOR_RANGE_MASK_DEFINES_SVH
`define HSV_COLOR_RANGE_MASK_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HCRM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds after the antecedent, delayed by the lat argument.
`define HCRM_ASSERT_DELAY(label, ante, lat, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##lat (cons)) \
      else $error(msg);

`endif

### design/hcrm_pkg.sv
`timescale 1ns / 1ps

package hcrm_pkg;

   localparam int unsigned FRAC_BITS = 12;
   localparam int unsigned SDIV_NUM = 255 << FRAC_BITS;
   localparam int unsigned HDIV_NUM = 180 << FRAC_BITS;
   localparam int unsigned SDIV_WIDTH = 20;
   localparam int unsigned HDIV_WIDTH = 17;
   localparam int unsigned MAG_WIDTH = 11;
   localparam int unsigned PROD_WIDTH = 28;
   localparam int unsigned HUE_SPAN = 180;
   localparam int unsigned PIPE_LATENCY = 6;

   localparam logic [7:0] WHITE = 8'd255;

   localparam logic [7:0] HUE_LOW_RESET = 8'd100;
   localparam logic [7:0] HUE_HIGH_RESET = 8'd130;
   localparam logic [7:0] SAT_LOW_RESET = 8'd40;
   localparam logic [7:0] SAT_HIGH_RESET = 8'd255;

   localparam logic [1:0] REG_HUE_LOW = 2'd0;
   localparam logic [1:0] REG_HUE_HIGH = 2'd1;
   localparam logic [1:0] REG_SAT_LOW = 2'd2;
   localparam logic [1:0] REG_SAT_HIGH = 2'd3;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic       in_range;
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } result_type;

endpackage

### design/hsv_color_range_mask.sv
`timescale 1ns / 1ps
`include "hsv_color_range_mask_defines.svh"

// Hue and saturation band mask for BGR pixels.
// A pixel is taken on req_pixel at each rising edge where start is high; busy
// is always low, so one pixel may be issued in every cycle.
// After a pixel is taken and has crossed the pipeline below, rsp_valid is high
// for one cycle and rsp_result carries the pass flag and the pixel, or white
// when it fails.
// One result leaves per cycle: the pixel crosses an input register, a max/min
// stage, a reciprocal table stage, a multiply stage, a rounding stage and the
// output register after the band compare.
// The receiver takes every result in the cycle it appears and cannot stall.
// The four band limits are written through the APB port at byte addresses
// 0, 4, 8 and 12 and should only change while no pixel is in flight.
// A synchronous reset empties the pipeline and restores the limits to hue
// (100, 130] and saturation (40, 255].
module hsv_color_range_mask (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hcrm_pkg::pixel_type   req_pixel,
   output logic                  rsp_valid,
   output hcrm_pkg::result_type  rsp_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int unsigned SdivW = hcrm_pkg::SDIV_WIDTH;
   localparam int unsigned HdivW = hcrm_pkg::HDIV_WIDTH;
   localparam int unsigned MagW = hcrm_pkg::MAG_WIDTH;
   localparam int unsigned ProdW = hcrm_pkg::PROD_WIDTH;
   localparam int unsigned FracB = hcrm_pkg::FRAC_BITS;
   localparam int unsigned PipeLat = hcrm_pkg::PIPE_LATENCY;
   localparam logic [23:0] AllWhite = {3{hcrm_pkg::WHITE}};

   logic [SdivW-1:0] sdiv_rom [256];
   logic [HdivW-1:0] hdiv_rom [256];

   assign sdiv_rom[0] = '0;
   assign hdiv_rom[0] = '0;
   for (genvar i = 1; i < 256; i++) begin : g_rom
      localparam int unsigned SdivVal = (2 * hcrm_pkg::SDIV_NUM + i) / (2 * i);
      localparam int unsigned HdivVal = (2 * hcrm_pkg::HDIV_NUM + 6 * i) / (12 * i);
      assign sdiv_rom[i] = SdivW'(SdivVal);
      assign hdiv_rom[i] = HdivW'(HdivVal);
   end

   logic [7:0] hue_low_ff, hue_low_in;
   logic [7:0] hue_high_ff, hue_high_in;
   logic [7:0] sat_low_ff, sat_low_in;
   logic [7:0] sat_high_ff, sat_high_in;
   logic       csr_write;

   assign pready = 1'b1;
   assign busy = 1'b0;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      hue_low_in = hue_low_ff;
      hue_high_in = hue_high_ff;
      sat_low_in = sat_low_ff;
      sat_high_in = sat_high_ff;
      if (csr_write) begin
         case (paddr[3:2])
            hcrm_pkg::REG_HUE_LOW: hue_low_in = pwdata[7:0];
            hcrm_pkg::REG_HUE_HIGH: hue_high_in = pwdata[7:0];
            hcrm_pkg::REG_SAT_LOW: sat_low_in = pwdata[7:0];
            hcrm_pkg::REG_SAT_HIGH: sat_high_in = pwdata[7:0];
            default: hue_low_in = hue_low_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         hcrm_pkg::REG_HUE_LOW: prdata = {24'd0, hue_low_ff};
         hcrm_pkg::REG_HUE_HIGH: prdata = {24'd0, hue_high_ff};
         hcrm_pkg::REG_SAT_LOW: prdata = {24'd0, sat_low_ff};
         hcrm_pkg::REG_SAT_HIGH: prdata = {24'd0, sat_high_ff};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff <= hcrm_pkg::HUE_LOW_RESET;
         hue_high_ff <= hcrm_pkg::HUE_HIGH_RESET;
         sat_low_ff <= hcrm_pkg::SAT_LOW_RESET;
         sat_high_ff <= hcrm_pkg::SAT_HIGH_RESET;
      end else begin
         hue_low_ff <= hue_low_in;
         hue_high_ff <= hue_high_in;
         sat_low_ff <= sat_low_in;
         sat_high_ff <= sat_high_in;
      end
   end

   // Stage 1: input register.
   logic                s1_valid_ff, s1_valid_in;
   hcrm_pkg::pixel_type s1_pix_ff, s1_pix_in;

   assign s1_valid_in = start && !busy;
   assign s1_pix_in = req_pixel;

   // Stage 2: max, min, spread and the signed hue numerator.
   logic                s2_valid_ff, s2_valid_in;
   hcrm_pkg::pixel_type s2_pix_ff, s2_pix_in;
   logic [7:0]          s2_v_ff, s2_v_in;
   logic [7:0]          s2_d_ff, s2_d_in;
   logic                s2_neg_ff, s2_neg_in;
   logic [MagW-1:0]     s2_mag_ff, s2_mag_in;
   logic [7:0]          s1_min;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_pix_in = s1_pix_ff;
      s2_v_in = s1_pix_ff.blue;
      s1_min = s1_pix_ff.blue;
      if (s1_pix_ff.green > s2_v_in) begin
         s2_v_in = s1_pix_ff.green;
      end
      if (s1_pix_ff.red > s2_v_in) begin
         s2_v_in = s1_pix_ff.red;
      end
      if (s1_pix_ff.green < s1_min) begin
         s1_min = s1_pix_ff.green;
      end
      if (s1_pix_ff.red < s1_min) begin
         s1_min = s1_pix_ff.red;
      end
      s2_d_in = s2_v_in - s1_min;
      s2_neg_in = 1'b0;
      if (s2_v_in == s1_pix_ff.red) begin
         if (s1_pix_ff.green >= s1_pix_ff.blue) begin
            s2_mag_in = MagW'(s1_pix_ff.green) - MagW'(s1_pix_ff.blue);
         end else begin
            s2_neg_in = 1'b1;
            s2_mag_in = MagW'(s1_pix_ff.blue) - MagW'(s1_pix_ff.green);
         end
      end else if (s2_v_in == s1_pix_ff.green) begin
         s2_mag_in = MagW'(s1_pix_ff.blue) + (MagW'(s2_d_in) << 1) - MagW'(s1_pix_ff.red);
      end else begin
         s2_mag_in = MagW'(s1_pix_ff.red) + (MagW'(s2_d_in) << 2) - MagW'(s1_pix_ff.green);
      end
   end

   // Stage 3: reciprocal lookups.
   logic                s3_valid_ff, s3_valid_in;
   hcrm_pkg::pixel_type s3_pix_ff, s3_pix_in;
   logic [7:0]          s3_d_ff, s3_d_in;
   logic                s3_neg_ff, s3_neg_in;
   logic [MagW-1:0]     s3_mag_ff, s3_mag_in;
   logic [SdivW-1:0]    s3_sdiv_ff, s3_sdiv_in;
   logic [HdivW-1:0]    s3_hdiv_ff, s3_hdiv_in;

   assign s3_valid_in = s2_valid_ff;
   assign s3_pix_in = s2_pix_ff;
   assign s3_d_in = s2_d_ff;
   assign s3_neg_in = s2_neg_ff;
   assign s3_mag_in = s2_mag_ff;
   assign s3_sdiv_in = sdiv_rom[s2_v_ff];
   assign s3_hdiv_in = hdiv_rom[s2_d_ff];

   // Stage 4: products.
   logic                s4_valid_ff, s4_valid_in;
   hcrm_pkg::pixel_type s4_pix_ff, s4_pix_in;
   logic                s4_neg_ff, s4_neg_in;
   logic [ProdW-1:0]    s4_sprod_ff, s4_sprod_in;
   logic [ProdW-1:0]    s4_hprod_ff, s4_hprod_in;

   assign s4_valid_in = s3_valid_ff;
   assign s4_pix_in = s3_pix_ff;
   assign s4_neg_in = s3_neg_ff;
   assign s4_sprod_in = ProdW'(s3_d_ff) * ProdW'(s3_sdiv_ff);
   assign s4_hprod_in = ProdW'(s3_mag_ff) * ProdW'(s3_hdiv_ff);

   // Stage 5: rounding, hue wrap and saturation clamp.
   logic                s5_valid_ff, s5_valid_in;
   hcrm_pkg::pixel_type s5_pix_ff, s5_pix_in;
   logic [7:0]          s5_hue_ff, s5_hue_in;
   logic [7:0]          s5_sat_ff, s5_sat_in;
   logic [ProdW:0]      sat_sum;
   logic [ProdW+1:0]    hue_sum;
   logic [ProdW+1:0]    hue_shift;
   logic signed [17:0]  hue_q;
   logic signed [17:0]  hue_w;

   always_comb begin
      s5_valid_in = s4_valid_ff;
      s5_pix_in = s4_pix_ff;
      sat_sum = {1'b0, s4_sprod_ff} + (ProdW + 1)'(1 << (FracB - 1));
      if (sat_sum[ProdW:FracB + 8] != '0) begin
         s5_sat_in = hcrm_pkg::WHITE;
      end else begin
         s5_sat_in = sat_sum[FracB + 7:FracB];
      end
      if (s4_neg_ff) begin
         hue_sum = (ProdW + 2)'(1 << (FracB - 1)) - {2'b00, s4_hprod_ff};
      end else begin
         hue_sum = (ProdW + 2)'(1 << (FracB - 1)) + {2'b00, s4_hprod_ff};
      end
      hue_shift = $unsigned($signed(hue_sum) >>> FracB);
      hue_q = $signed(hue_shift[17:0]);
      hue_w = hue_q;
      if (hue_q < 18'sd0) begin
         hue_w = hue_q + 18'(hcrm_pkg::HUE_SPAN);
      end
      if (hue_w >= 18'(hcrm_pkg::HUE_SPAN)) begin
         hue_w = hue_w - 18'(hcrm_pkg::HUE_SPAN);
      end
      s5_hue_in = hue_w[7:0];
   end

   // Output stage: band compare and composite onto white.
   logic                 rsp_valid_ff, rsp_valid_in;
   hcrm_pkg::result_type rsp_result_ff, rsp_result_in;
   logic                 hue_above;
   logic                 hue_below;
   logic                 hue_ok;
   logic                 sat_ok;

   always_comb begin
      rsp_valid_in = s5_valid_ff;
      hue_above = s5_hue_ff > hue_low_ff;
      hue_below = s5_hue_ff <= hue_high_ff;
      hue_ok = (hue_low_ff < hue_high_ff) ? (hue_above && hue_below)
                                          : (hue_above || hue_below);
      sat_ok = (s5_sat_ff > sat_low_ff) && (s5_sat_ff <= sat_high_ff);
      rsp_result_in.in_range = hue_ok && sat_ok;
      if (hue_ok && sat_ok) begin
         rsp_result_in.out_blue = s5_pix_ff.blue;
         rsp_result_in.out_green = s5_pix_ff.green;
         rsp_result_in.out_red = s5_pix_ff.red;
      end else begin
         rsp_result_in.out_blue = hcrm_pkg::WHITE;
         rsp_result_in.out_green = hcrm_pkg::WHITE;
         rsp_result_in.out_red = hcrm_pkg::WHITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff <= s1_pix_in;
      s2_pix_ff <= s2_pix_in;
      s2_v_ff <= s2_v_in;
      s2_d_ff <= s2_d_in;
      s2_neg_ff <= s2_neg_in;
      s2_mag_ff <= s2_mag_in;
      s3_pix_ff <= s3_pix_in;
      s3_d_ff <= s3_d_in;
      s3_neg_ff <= s3_neg_in;
      s3_mag_ff <= s3_mag_in;
      s3_sdiv_ff <= s3_sdiv_in;
      s3_hdiv_ff <= s3_hdiv_in;
      s4_pix_ff <= s4_pix_in;
      s4_neg_ff <= s4_neg_in;
      s4_sprod_ff <= s4_sprod_in;
      s4_hprod_ff <= s4_hprod_in;
      s5_pix_ff <= s5_pix_in;
      s5_hue_ff <= s5_hue_in;
      s5_sat_ff <= s5_sat_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   logic [23:0] rsp_pix;
   logic        rsp_fail;
   logic        rsp_keep;

   assign rsp_pix = {rsp_result.out_blue, rsp_result.out_green, rsp_result.out_red};
   assign rsp_fail = rsp_valid && !rsp_result.in_range;
   assign rsp_keep = rsp_valid && rsp_result.in_range;

   `HCRM_ASSERT_DELAY(a_latency, start && !busy, PipeLat, rsp_valid, "Item gave no result.")
   `HCRM_ASSERT_IMPL(a_no_phantom, rsp_valid, $past(start, PipeLat), "Result without an item.")
   `HCRM_ASSERT_IMPL(a_white_fail, rsp_fail, rsp_pix == AllWhite, "Failing pixel is not white.")
   `HCRM_ASSERT_IMPL(a_pass_keep, rsp_keep, rsp_pix == $past(req_pixel, PipeLat), "Pixel altered.")

endmodule
